[rtl/core/mbce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_pkg
// Shared types and constants for the monochrome bitmap clip expander.
// ----------------------------------------------------------------------------
package mbce_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int BYTE_BITS  = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ORIGIN  = 3'd0,
		REG_BITMAP_WIDTH  = 3'd1,
		REG_BITMAP_HEIGHT = 3'd2,
		REG_CLIP_ORIGIN   = 3'd3,
		REG_CLIP_WIDTH    = 3'd4,
		REG_CLIP_HEIGHT   = 3'd5,
		REG_FORE_COLOUR   = 3'd6,
		REG_BACK_COLOUR   = 3'd7
	} mbce_reg_t;

	localparam logic [31:0] RST_IMAGE_ORIGIN  = 32'h0000_0000;
	localparam logic [10:0] RST_BITMAP_WIDTH  = 11'd8;
	localparam logic [15:0] RST_BITMAP_HEIGHT = 16'd1;
	localparam logic [31:0] RST_CLIP_ORIGIN   = 32'h0000_0000;
	localparam logic [15:0] RST_CLIP_WIDTH    = 16'hFFFF;
	localparam logic [15:0] RST_CLIP_HEIGHT   = 16'hFFFF;
	localparam logic [23:0] RST_FORE_COLOUR   = 24'hFFFFFF;
	localparam logic [23:0] RST_BACK_COLOUR   = 24'h000000;

	typedef struct packed {
		logic [31:0] image_origin;
		logic [10:0] bmp_w;
		logic [15:0] bmp_h;
		logic [31:0] clip_origin;
		logic [15:0] clip_w;
		logic [15:0] clip_h;
		logic [23:0] fore_colour;
		logic [23:0] back_colour;
	} mbce_cfg_t;

	// one byte's worth of work: mask lane k is pixel k from the left, data bit 7-k
	typedef struct packed {
		logic [BYTE_BITS-1:0] mask;
		logic [BYTE_BITS-1:0] data;
		logic [15:0]          base_x;
		logic [15:0]          py;
	} mbce_word_t;

endpackage

[rtl/core/mono_bitmap_clip_expander_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_clip_expander_top
// Expands 1-bpp bitmap bytes into clipped pixel writes (x, y, color).
// ----------------------------------------------------------------------------
// A byte is held in the byte buffer and each visible pixel is then registered
//   in the output register. Throughput: one pixel per cycle from the
//   serializer unless the output stalls; a byte holds the byte buffer until its
//   last visible pixel (eight at most) is sent, a byte with none not at all.
// Reset: counters cleared, registers at defaults, no pixel pending.
// Any register write clears the row and byte counters.
// ----------------------------------------------------------------------------
module mono_bitmap_clip_expander_top import mbce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_BITS-1:0]  bitmap_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    pixel_x,
	output logic signed [15:0]    pixel_y,
	output logic [23:0]           pixel_color,
	output logic                  last_of_byte
);

	mbce_cfg_t  cfg;
	mbce_word_t word;
	logic       accept;

	assign accept = in_valid && in_ready;

	mbce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbce_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clear       (cfg_we),
		.accept      (accept),
		.bitmap_byte (bitmap_byte),
		.word        (word)
	);

	mbce_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.word         (word),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_of_byte (last_of_byte)
	);

endmodule

[rtl/core/mbce_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module mbce_cfg import mbce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mbce_cfg_t             cfg
);

	mbce_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_origin <= RST_IMAGE_ORIGIN;
			cfg_q.bmp_w        <= RST_BITMAP_WIDTH;
			cfg_q.bmp_h        <= RST_BITMAP_HEIGHT;
			cfg_q.clip_origin  <= RST_CLIP_ORIGIN;
			cfg_q.clip_w       <= RST_CLIP_WIDTH;
			cfg_q.clip_h       <= RST_CLIP_HEIGHT;
			cfg_q.fore_colour  <= RST_FORE_COLOUR;
			cfg_q.back_colour  <= RST_BACK_COLOUR;
		end else if (cfg_we) begin
			unique case (mbce_reg_t'(cfg_index))
				REG_IMAGE_ORIGIN:  cfg_q.image_origin <= cfg_data;
				REG_BITMAP_WIDTH:  cfg_q.bmp_w        <= cfg_data[10:0];
				REG_BITMAP_HEIGHT: cfg_q.bmp_h        <= cfg_data[15:0];
				REG_CLIP_ORIGIN:   cfg_q.clip_origin  <= cfg_data;
				REG_CLIP_WIDTH:    cfg_q.clip_w       <= cfg_data[15:0];
				REG_CLIP_HEIGHT:   cfg_q.clip_h       <= cfg_data[15:0];
				REG_FORE_COLOUR:   cfg_q.fore_colour  <= cfg_data[23:0];
				REG_BACK_COLOUR:   cfg_q.back_colour  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/mbce_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_gen
// Row/byte counters and per-lane width and clip tests for the incoming byte.
// ----------------------------------------------------------------------------
module mbce_gen import mbce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbce_cfg_t            cfg,
	input  logic                 clear,
	input  logic                 accept,
	input  logic [BYTE_BITS-1:0] bitmap_byte,
	output mbce_word_t           word
);

	logic [15:0] row_q;
	logic [7:0]  bir_q;

	logic [17:0] sx, sy, cx, cy, cx_end, cy_end, py_w;
	logic        row_in;
	logic [8:0]  row_bytes;
	logic [8:0]  bir_inc;
	logic [16:0] row_inc;
	logic [BYTE_BITS-1:0] lane_ok;

	assign sx     = {{2{cfg.image_origin[15]}}, cfg.image_origin[15:0]};
	assign sy     = {{2{cfg.image_origin[31]}}, cfg.image_origin[31:16]};
	assign cx     = {{2{cfg.clip_origin[15]}}, cfg.clip_origin[15:0]};
	assign cy     = {{2{cfg.clip_origin[31]}}, cfg.clip_origin[31:16]};
	assign cx_end = cx + {2'b00, cfg.clip_w};
	assign cy_end = cy + {2'b00, cfg.clip_h};
	assign py_w   = {2'b00, row_q} + sy;

	assign row_in = (cfg.bmp_h != '0) &&
	                ($signed(py_w) >= $signed(cy)) && ($signed(py_w) < $signed(cy_end));

	always_comb begin
		logic [10:0] idx;
		logic [17:0] px;
		for (int k = 0; k < BYTE_BITS; k++) begin
			idx = {bir_q, 3'(k)};
			px  = {7'd0, idx} + sx;
			lane_ok[k] = row_in && (idx < cfg.bmp_w) &&
			             ($signed(px) >= $signed(cx)) && ($signed(px) < $signed(cx_end));
		end
	end

	assign word.mask   = lane_ok;
	assign word.data   = bitmap_byte;
	assign word.base_x = {5'd0, bir_q, 3'd0} + cfg.image_origin[15:0];
	assign word.py     = py_w[15:0];

	assign row_bytes = 9'((12'(cfg.bmp_w) + 12'd7) >> 3);
	assign bir_inc   = {1'b0, bir_q} + 9'd1;
	assign row_inc   = {1'b0, row_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			bir_q <= '0;
		end else if (clear) begin
			row_q <= '0;
			bir_q <= '0;
		end else if (accept) begin
			priority if (cfg.bmp_h == '0) begin
				row_q <= '0;
				bir_q <= '0;
			end else if (bir_inc >= row_bytes) begin
				bir_q <= '0;
				if (row_inc >= {1'b0, cfg.bmp_h}) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[15:0];
				end
			end else begin
				bir_q <= bir_inc[7:0];
			end
		end
	end

endmodule

[rtl/core/mbce_ser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_ser
// Byte buffer and pixel serializer: one pixel word per cycle into the
// output register unless the output stalls, leftmost pixel first.
// ----------------------------------------------------------------------------
module mbce_ser import mbce_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mbce_cfg_t           cfg,
	input  logic                accept,
	input  mbce_word_t          word,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  pixel_x,
	output logic signed [15:0]  pixel_y,
	output logic [23:0]         pixel_color,
	output logic                last_of_byte
);

	logic [BYTE_BITS-1:0] mask_s1;
	logic [BYTE_BITS-1:0] data_s1;
	logic [15:0]          base_x_s1;
	logic [15:0]          py_s1;

	logic                 out_valid_s2;
	logic [15:0]          px_s2;
	logic [15:0]          py_s2;
	logic [23:0]          colour_s2;
	logic                 last_s2;

	logic [BYTE_BITS-1:0] pick;
	logic [BYTE_BITS-1:0] rem;
	logic [2:0]           pick_idx;
	logic                 buf_valid;
	logic                 pop;
	logic                 pick_last;

	assign buf_valid = (mask_s1 != '0);
	assign pick      = mask_s1 & (~mask_s1 + 8'd1);
	assign rem       = mask_s1 & ~pick;
	assign pick_last = (rem == '0);
	assign pop       = buf_valid && (!out_valid_s2 || out_ready);
	assign in_ready  = !buf_valid || (pop && pick_last);

	always_comb begin
		pick_idx = '0;
		for (int k = 0; k < BYTE_BITS; k++) begin
			if (pick[k]) begin
				pick_idx = 3'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1      <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				mask_s1 <= word.mask;
			end else if (pop) begin
				mask_s1 <= rem;
			end
			if (pop) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1   <= word.data;
			base_x_s1 <= word.base_x;
			py_s1     <= word.py;
		end
		if (pop) begin
			px_s2     <= base_x_s1 + {13'd0, pick_idx};
			py_s2     <= py_s1;
			colour_s2 <= data_s1[~pick_idx] ? cfg.back_colour : cfg.fore_colour;
			last_s2   <= pick_last;
		end
	end

	assign out_valid    = out_valid_s2;
	assign pixel_x      = $signed(px_s2);
	assign pixel_y      = $signed(py_s2);
	assign pixel_color  = colour_s2;
	assign last_of_byte = last_s2;

`ifndef SYNTHESIS
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (mask_s1 == $past(word.mask)))
		else $error("byte buffer not loaded on accept");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !pick_last) |=> (buf_valid && !$past(accept)))
		else $error("byte dropped pixels or took a word while busy");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_s2)
		else $error("popped pixel did not reach output register");
`endif

endmodule
